// File: rtl/ope_pkg.sv
// shared types and constants of the operator precedence evaluator
// token kinds, status codes, precedence table, controller/datapath structs
// no dependencies
package ope_pkg;

	localparam logic [2:0] TK_ID  = 3'd0;
	localparam logic [2:0] TK_ADD = 3'd1;
	localparam logic [2:0] TK_SUB = 3'd2;
	localparam logic [2:0] TK_MUL = 3'd3;
	localparam logic [2:0] TK_DIV = 3'd4;
	localparam logic [2:0] TK_END = 3'd5;

	localparam logic [2:0] ST_SHIFT    = 3'd0;
	localparam logic [2:0] ST_ACCEPT   = 3'd1;
	localparam logic [2:0] ST_SYNTAX   = 3'd2;
	localparam logic [2:0] ST_DIVZERO  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_SKIP     = 3'd5;

	localparam logic [1:0] REL_NONE   = 2'd0;
	localparam logic [1:0] REL_SHIFT  = 2'd1;
	localparam logic [1:0] REL_REDUCE = 2'd2;

	localparam logic signed [47:0] POS48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] NEG48 = 48'sh8000_0000_0000;

	typedef enum logic [1:0] {
		DEC_FINISH = 2'd0,
		DEC_LOOP   = 2'd1,
		DEC_ALU    = 2'd2
	} ope_dec_t;

	typedef struct packed {
		logic load;
		logic step;
		logic alu_commit;
		logic emit;
	} ope_cmd_t;

	typedef struct packed {
		ope_dec_t dec;
		logic     alu_done;
	} ope_stat_t;

	// precedence of stack top (row) against incoming token (column)
	function automatic logic [1:0] prec_rel(input logic [2:0] top, input logic [2:0] kind);
		logic [1:0] rel;
		rel = REL_NONE;
		case (top)
			TK_ID: begin
				rel = (kind == TK_ID) ? REL_NONE : REL_REDUCE;
			end
			TK_ADD, TK_SUB: begin
				rel = (kind == TK_ID || kind == TK_MUL || kind == TK_DIV) ? REL_SHIFT
					: REL_REDUCE;
			end
			TK_MUL, TK_DIV: begin
				rel = (kind == TK_ID) ? REL_SHIFT : REL_REDUCE;
			end
			TK_END: begin
				rel = (kind == TK_END) ? REL_NONE : REL_SHIFT;
			end
			default: begin
				rel = REL_NONE;
			end
		endcase
		return rel;
	endfunction

endpackage

// File: rtl/operator_precedence_evaluator.sv
// top level of the operator precedence expression evaluator
// joins ope_ctrl and ope_datapath; depends on ope_pkg
//
// usage:
//  - input channel (in_valid/in_stall, token_kind, operand_value) takes one
//    token per transfer: identifier with its integer value, + - * /, or end
//  - output channel (out_valid/out_stall, status, result_value) gives exactly
//    one result per token: shifted, accepted with value, syntax error,
//    divide by zero, stack overflow, or skipped after an error
//  - one token at a time: in_stall is high from the transfer until the
//    result has moved into the output register
//  - time per token grows with each reduce, multiply and divide; the shared
//    bit-serial divider sets the worst case
//  - the output register parts the channels: a new token is taken while
//    the previous result still waits under out_stall
//  - reset clears stack counts, the error flag and out_valid at once; stack
//    memories need no clearing pass
module operator_precedence_evaluator #(
	parameter int STACK_DEPTH   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         token_kind,
	input  logic signed [31:0] operand_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [47:0] result_value
);
	import ope_pkg::*;

	// commands from controller, decision and alu status back
	ope_cmd_t  cmd;
	ope_stat_t stat;

	ope_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stacks, saturating arithmetic and the result register
	ope_datapath #(
		.STACK_DEPTH  (STACK_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.token_kind   (token_kind),
		.operand_value(operand_value),
		.status       (status),
		.result_value (result_value)
	);

endmodule

// File: rtl/ope_alu.sv
// multi-cycle multiply/divide unit for signed fixed-point values
// one 24x24 multiplier over four partial products, restoring divider one bit a cycle
// depends on ope_pkg
module ope_alu #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               is_div,
	input  logic signed [47:0] lhs,
	input  logic signed [47:0] rhs,
	output logic               done,
	output logic signed [47:0] res
);
	import ope_pkg::*;

	localparam int DIV_STEPS = 48 + FRACTION_BITS;
	localparam int MUL_STEPS = 5;
	localparam int CNTW      = $clog2(DIV_STEPS + 1);

	logic            busy_q, is_div_q, neg_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [47:0]     a_q, b_q, rem_q;
	logic [47:0]     prod_s1;
	logic [1:0]      sh_s1;
	logic [95:0]     acc_q;
	logic [DIV_STEPS-1:0] dv_q, quo_q;
	logic signed [47:0] res_q;

	logic [47:0] lmag, rmag;
	logic [23:0] a_part, b_part;
	logic [48:0] trial;
	logic        ge;
	logic [CNTW-1:0] last;
	logic [95:0] wide, pp_shift;
	logic [47:0] cap, magc;

	assign lmag = lhs[47] ? 48'(-lhs) : 48'(lhs);
	assign rmag = rhs[47] ? 48'(-rhs) : 48'(rhs);

	assign a_part = cnt_q[1] ? a_q[47:24] : a_q[23:0];
	assign b_part = cnt_q[0] ? b_q[47:24] : b_q[23:0];

	assign trial = {rem_q, dv_q[DIV_STEPS-1]};
	assign ge    = trial >= {1'b0, b_q};
	assign last  = is_div_q ? CNTW'(DIV_STEPS) : CNTW'(MUL_STEPS);

	always_comb begin
		case (sh_s1)
			2'd0: pp_shift = 96'(prod_s1);
			2'd1: pp_shift = 96'(prod_s1) << 24;
			2'd2: pp_shift = 96'(prod_s1) << 48;
			default: pp_shift = '0;
		endcase
	end

	// magnitude, saturated to the sign's limit
	assign wide = is_div_q ? 96'(quo_q) : (acc_q >> FRACTION_BITS);
	assign cap  = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	assign magc = (wide > 96'(cap)) ? cap : wide[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNTW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= lmag;
			b_q      <= rmag;
			neg_q    <= lhs[47] ^ rhs[47];
			is_div_q <= is_div;
			acc_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			dv_q     <= DIV_STEPS'(lmag) << FRACTION_BITS;
		end else if (busy_q) begin
			if (is_div_q) begin
				if (cnt_q < CNTW'(DIV_STEPS)) begin
					rem_q <= ge ? 48'(trial - {1'b0, b_q}) : trial[47:0];
					dv_q  <= dv_q << 1;
					quo_q <= {quo_q[DIV_STEPS-2:0], ge};
				end
			end else begin
				if (cnt_q < CNTW'(4)) begin
					prod_s1 <= a_part * b_part;
					sh_s1   <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
				end
				if (cnt_q >= CNTW'(1) && cnt_q <= CNTW'(4)) begin
					acc_q <= acc_q + pp_shift;
				end
			end
			if (cnt_q == last) begin
				res_q <= neg_q ? -$signed(magc) : $signed(magc);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: rtl/ope_datapath.sv
// datapath of the evaluator: symbol and value stacks, token and result registers
// add/sub saturation and the precedence decision; multiply/divide via ope_alu
// depends on ope_pkg and ope_alu
module ope_datapath #(
	parameter int STACK_DEPTH   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ope_pkg::ope_cmd_t  cmd,
	output ope_pkg::ope_stat_t stat,
	input  logic [2:0]         token_kind,
	input  logic signed [31:0] operand_value,
	output logic [2:0]         status,
	output logic signed [47:0] result_value
);
	import ope_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = 49 + FRACTION_BITS;
	localparam logic signed [SW-1:0] POS_W = SW'(POS48);
	localparam logic signed [SW-1:0] NEG_W = SW'(NEG48);

	logic [2:0]         sym_mem [STACK_DEPTH];
	logic signed [47:0] val_mem [STACK_DEPTH];

	logic [CW-1:0]      sym_cnt_q, val_cnt_q;
	logic               failed_q;
	logic [2:0]         tok_kind_q;
	logic signed [31:0] tok_val_q;
	logic [2:0]         sym_rd_q;
	logic signed [47:0] val_top_q, val_nxt_q;
	logic [2:0]         pend_status_q;
	logic signed [47:0] pend_value_q;

	logic [CW-1:0] sym_m1, val_m1, val_m2;
	logic [2:0]    top;
	logic [1:0]    rel;
	ope_dec_t      dec;
	logic [2:0]    fin_status;
	logic signed [47:0] fin_value;
	logic push, pop_sym, combine, alu_go, do_clear, set_fail, clr_fail;
	logic signed [SW-1:0] scaled;
	logic signed [47:0] val_scaled, as_res, alu_res, val_wd;
	logic signed [48:0] as_sum;
	logic [AW-1:0] val_wa;
	logic sym_we, val_we, alu_done;

	assign sym_m1 = sym_cnt_q - CW'(1);
	assign val_m1 = val_cnt_q - CW'(1);
	assign val_m2 = val_cnt_q - CW'(2);

	// identifier scaled to fixed point, saturated
	assign scaled     = SW'(tok_val_q) <<< FRACTION_BITS;
	assign val_scaled = (scaled > POS_W) ? POS48 : (scaled < NEG_W) ? NEG48 : scaled[47:0];

	assign as_sum = (top == TK_SUB) ? ({val_nxt_q[47], val_nxt_q} - {val_top_q[47], val_top_q})
		: ({val_nxt_q[47], val_nxt_q} + {val_top_q[47], val_top_q});
	assign as_res = (as_sum[48] != as_sum[47]) ? (as_sum[48] ? NEG48 : POS48) : as_sum[47:0];

	assign top = (sym_cnt_q == '0 || sym_rd_q > TK_END) ? TK_END : sym_rd_q;
	assign rel = prec_rel(top, tok_kind_q);

	always_comb begin
		dec        = DEC_FINISH;
		fin_status = ST_SYNTAX;
		fin_value  = '0;
		push       = 1'b0;
		pop_sym    = 1'b0;
		combine    = 1'b0;
		alu_go     = 1'b0;
		do_clear   = 1'b0;
		set_fail   = 1'b0;
		clr_fail   = 1'b0;
		if (failed_q) begin
			fin_status = ST_SKIP;
			if (tok_kind_q == TK_END) begin
				do_clear = 1'b1;
				clr_fail = 1'b1;
			end
		end else if (tok_kind_q > TK_END) begin
			fin_status = ST_SYNTAX;
		end else if (top == TK_END && tok_kind_q == TK_END) begin
			if (val_cnt_q != '0) begin
				fin_status = ST_ACCEPT;
				fin_value  = val_top_q;
				do_clear   = 1'b1;
			end
		end else if (rel == REL_SHIFT) begin
			if (sym_cnt_q >= CW'(STACK_DEPTH) ||
				(tok_kind_q == TK_ID && val_cnt_q >= CW'(STACK_DEPTH))) begin
				fin_status = ST_OVERFLOW;
			end else begin
				fin_status = ST_SHIFT;
				push       = 1'b1;
			end
		end else if (rel == REL_REDUCE) begin
			if (top == TK_ID) begin
				dec     = DEC_LOOP;
				pop_sym = 1'b1;
			end else if (val_cnt_q < CW'(2)) begin
				fin_status = ST_SYNTAX;
			end else if (top == TK_DIV && val_top_q == '0) begin
				fin_status = ST_DIVZERO;
			end else if (top == TK_ADD || top == TK_SUB) begin
				dec     = DEC_LOOP;
				combine = 1'b1;
			end else begin
				dec    = DEC_ALU;
				alu_go = 1'b1;
			end
		end
		// error: end marker clears the stacks, anything else starts a skip
		if (dec == DEC_FINISH && fin_status != ST_SKIP && fin_status >= ST_SYNTAX) begin
			fin_value = '0;
			if (tok_kind_q == TK_END) begin
				do_clear = 1'b1;
			end else begin
				set_fail = 1'b1;
			end
		end
	end

	assign sym_we = cmd.step && push;
	assign val_we = (cmd.step && ((push && tok_kind_q == TK_ID) || combine)) || cmd.alu_commit;
	assign val_wa = push ? val_cnt_q[AW-1:0] : val_m2[AW-1:0];
	assign val_wd = cmd.alu_commit ? alu_res : (push ? val_scaled : as_res);

	always_ff @(posedge clk) begin
		sym_rd_q  <= sym_mem[sym_m1[AW-1:0]];
		val_top_q <= val_mem[val_m1[AW-1:0]];
		val_nxt_q <= val_mem[val_m2[AW-1:0]];
		if (sym_we) begin
			sym_mem[sym_cnt_q[AW-1:0]] <= tok_kind_q;
		end
		if (val_we) begin
			val_mem[val_wa] <= val_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_cnt_q <= '0;
			val_cnt_q <= '0;
			failed_q  <= 1'b0;
		end else begin
			if (cmd.step) begin
				if (do_clear) begin
					sym_cnt_q <= '0;
					val_cnt_q <= '0;
				end else if (push) begin
					sym_cnt_q <= sym_cnt_q + CW'(1);
					if (tok_kind_q == TK_ID) begin
						val_cnt_q <= val_cnt_q + CW'(1);
					end
				end else if (pop_sym) begin
					sym_cnt_q <= sym_m1;
				end else if (combine) begin
					sym_cnt_q <= sym_m1;
					val_cnt_q <= val_m1;
				end
				if (set_fail) begin
					failed_q <= 1'b1;
				end else if (clr_fail) begin
					failed_q <= 1'b0;
				end
			end
			if (cmd.alu_commit) begin
				sym_cnt_q <= sym_m1;
				val_cnt_q <= val_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tok_kind_q <= token_kind;
			tok_val_q  <= operand_value;
		end
		if (cmd.step && dec == DEC_FINISH) begin
			pend_status_q <= fin_status;
			pend_value_q  <= fin_value;
		end
		if (cmd.emit) begin
			status       <= pend_status_q;
			result_value <= pend_value_q;
		end
	end

	ope_alu #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.step && alu_go),
		.is_div(top == TK_DIV),
		.lhs   (val_nxt_q),
		.rhs   (val_top_q),
		.done  (alu_done),
		.res   (alu_res)
	);

	assign stat.dec      = dec;
	assign stat.alu_done = alu_done;

	a_sym_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sym_cnt_q <= CW'(STACK_DEPTH))
		else $error("symbol count beyond stack depth");

	a_val_bound: assert property (@(posedge clk) disable iff (!arst_n)
		val_cnt_q <= CW'(STACK_DEPTH))
		else $error("value count beyond stack depth");

	a_accept_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && dec == DEC_FINISH && fin_status == ST_ACCEPT)
		|=> (sym_cnt_q == '0 && val_cnt_q == '0))
		else $error("stacks not cleared after accept");

endmodule

// File: rtl/ope_ctrl.sv
// controller state machine of the evaluator
// sequences load, stack read, decision, alu wait and result transfer
// depends on ope_pkg
module ope_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ope_pkg::ope_stat_t stat,
	output ope_pkg::ope_cmd_t  cmd
);
	import ope_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_WAIT   = 5'b01000,
		S_EMIT   = 5'b10000
	} ope_state_t;

	ope_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.step = 1'b1;
				case (stat.dec)
					DEC_LOOP: state_d = S_READ;
					DEC_ALU:  state_d = S_WAIT;
					default:  state_d = S_EMIT;
				endcase
			end
			S_WAIT: begin
				if (stat.alu_done) begin
					cmd.alu_commit = 1'b1;
					state_d        = S_READ;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.alu_done |-> state_q == S_WAIT)
		else $error("alu finished outside wait state");

endmodule
